@@ rtl/ibhq_pkg.sv @@
package ibhq_pkg;

	localparam int TAG_W     = 8;
	localparam int TAG_COUNT = 256;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_FRONT  = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_FULL    = 3'd2,
		ST_ABSENT  = 3'd3,
		ST_PRESENT = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POS,
		S_TGT,
		S_LAST,
		S_UP,
		S_UP_CMP,
		S_DOWN,
		S_DN_L,
		S_DN_R,
		S_DN_DEC,
		S_PUT,
		S_DONE
	} state_t;

endpackage

@@ rtl/ibhq_ram.sv @@
module ibhq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/ibhq_ctrl.sv @@
module ibhq_ctrl #(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 16,
	parameter int POS_W    = 8,
	parameter int CNT_W    = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [1:0]                        opcode,
	input  logic [KEY_BITS-1:0]               key,
	input  logic [ibhq_pkg::TAG_W-1:0]        tag,
	input  logic                              order_max,
	output logic                              busy,
	output logic                              done,
	output logic [2:0]                        status,
	output logic [KEY_BITS-1:0]               out_key,
	output logic [ibhq_pkg::TAG_W-1:0]        out_tag,
	output logic [CNT_W-1:0]                  occupancy,
	output logic                              s_we,
	output logic [POS_W-1:0]                  s_waddr,
	output logic [KEY_BITS+ibhq_pkg::TAG_W-1:0] s_wdata,
	output logic [POS_W-1:0]                  s_raddr,
	input  logic [KEY_BITS+ibhq_pkg::TAG_W-1:0] s_rdata,
	output logic                              p_we,
	output logic [ibhq_pkg::TAG_W-1:0]        p_waddr,
	output logic [POS_W-1:0]                  p_wdata,
	output logic [ibhq_pkg::TAG_W-1:0]        p_raddr,
	input  logic [POS_W-1:0]                  p_rdata
);

	localparam int TW = ibhq_pkg::TAG_W;
	localparam int XW = POS_W + 2;

	ibhq_pkg::state_t  state_q, state_d;
	ibhq_pkg::op_t     op_q;
	ibhq_pkg::status_t status_q;

	logic [KEY_BITS-1:0] m_key_q, best_key_q, okey_q;
	logic [TW-1:0]       m_tag_q, best_tag_q, otag_q;
	logic [POS_W-1:0]    idx_q, pos_q, best_idx_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                first_q, best_mov_q;
	logic [ibhq_pkg::TAG_COUNT-1:0] held_q;

	logic [KEY_BITS-1:0] rd_key;
	logic [TW-1:0]       rd_tag;
	logic [POS_W-1:0]    parent;
	logic [XW-1:0]       lw, rw, cnt_x;
	logic [CNT_W-1:0]    last;
	logic [KEY_BITS-1:0] cmp_a, cmp_b;
	logic                below;

	assign rd_key = s_rdata[KEY_BITS+TW-1:TW];
	assign rd_tag = s_rdata[TW-1:0];
	assign parent = (idx_q - POS_W'(1)) >> 1;
	assign lw     = {1'b0, idx_q, 1'b1};
	assign rw     = lw + XW'(1);
	assign cnt_x  = XW'(cnt_q);
	assign last   = cnt_q - CNT_W'(1);
	assign p_raddr = tag;

	// shared comparator: true when b belongs above a
	always_comb begin
		case (state_q)
			ibhq_pkg::S_DN_L: begin cmp_a = m_key_q;    cmp_b = rd_key; end
			ibhq_pkg::S_DN_R: begin cmp_a = best_key_q; cmp_b = rd_key; end
			default:          begin cmp_a = rd_key;     cmp_b = m_key_q; end
		endcase
		below = order_max ? (cmp_a < cmp_b) : (cmp_a > cmp_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibhq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		s_we    = 1'b0;
		s_waddr = idx_q;
		s_wdata = {m_key_q, m_tag_q};
		s_raddr = parent;
		p_we    = 1'b0;
		p_waddr = m_tag_q;
		p_wdata = idx_q;
		case (state_q)
			ibhq_pkg::S_IDLE: begin
				s_raddr = '0;
				if (start) begin
					case (ibhq_pkg::op_t'(opcode))
						ibhq_pkg::OP_INSERT: begin
							if (held_q[tag] || cnt_q == CNT_W'(CAPACITY))
								state_d = ibhq_pkg::S_DONE;
							else
								state_d = ibhq_pkg::S_UP;
						end
						ibhq_pkg::OP_REMOVE: begin
							state_d = held_q[tag] ? ibhq_pkg::S_POS : ibhq_pkg::S_DONE;
						end
						default: begin
							state_d = (cnt_q == '0) ? ibhq_pkg::S_DONE : ibhq_pkg::S_TGT;
						end
					endcase
				end
			end
			ibhq_pkg::S_POS: begin
				s_raddr = p_rdata;
				state_d = (CNT_W'(p_rdata) >= cnt_q) ? ibhq_pkg::S_DONE : ibhq_pkg::S_TGT;
			end
			ibhq_pkg::S_TGT: begin
				s_raddr = last[POS_W-1:0];
				if (op_q == ibhq_pkg::OP_FRONT || CNT_W'(pos_q) == last)
					state_d = ibhq_pkg::S_DONE;
				else
					state_d = ibhq_pkg::S_LAST;
			end
			ibhq_pkg::S_LAST: begin
				state_d = (pos_q == '0) ? ibhq_pkg::S_DOWN : ibhq_pkg::S_UP;
			end
			ibhq_pkg::S_UP: begin
				state_d = (idx_q == '0) ? ibhq_pkg::S_PUT : ibhq_pkg::S_UP_CMP;
			end
			ibhq_pkg::S_UP_CMP: begin
				if (below) begin
					// move the parent down into the hole
					s_we    = 1'b1;
					s_wdata = s_rdata;
					p_we    = 1'b1;
					p_waddr = rd_tag;
					state_d = ibhq_pkg::S_UP;
				end else begin
					state_d = first_q ? ibhq_pkg::S_DOWN : ibhq_pkg::S_PUT;
				end
			end
			ibhq_pkg::S_DOWN: begin
				s_raddr = lw[POS_W-1:0];
				state_d = (lw >= cnt_x) ? ibhq_pkg::S_PUT : ibhq_pkg::S_DN_L;
			end
			ibhq_pkg::S_DN_L: begin
				s_raddr = rw[POS_W-1:0];
				state_d = (rw < cnt_x) ? ibhq_pkg::S_DN_R : ibhq_pkg::S_DN_DEC;
			end
			ibhq_pkg::S_DN_R: begin
				state_d = ibhq_pkg::S_DN_DEC;
			end
			ibhq_pkg::S_DN_DEC: begin
				if (best_mov_q) begin
					state_d = ibhq_pkg::S_PUT;
				end else begin
					s_we    = 1'b1;
					s_wdata = {best_key_q, best_tag_q};
					p_we    = 1'b1;
					p_waddr = best_tag_q;
					state_d = ibhq_pkg::S_DOWN;
				end
			end
			ibhq_pkg::S_PUT: begin
				s_we    = 1'b1;
				p_we    = 1'b1;
				state_d = ibhq_pkg::S_DONE;
			end
			ibhq_pkg::S_DONE: begin
				state_d = ibhq_pkg::S_IDLE;
			end
			default: begin
				state_d = ibhq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			held_q <= '0;
		end else begin
			if (state_q == ibhq_pkg::S_IDLE && start && state_d == ibhq_pkg::S_UP) begin
				cnt_q       <= cnt_q + CNT_W'(1);
				held_q[tag] <= 1'b1;
			end
			if (state_q == ibhq_pkg::S_TGT && op_q != ibhq_pkg::OP_FRONT) begin
				cnt_q          <= last;
				held_q[rd_tag] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ibhq_pkg::S_IDLE: begin
				op_q     <= ibhq_pkg::op_t'(opcode);
				okey_q   <= '0;
				otag_q   <= '0;
				m_key_q  <= key;
				m_tag_q  <= tag;
				idx_q    <= cnt_q[POS_W-1:0];
				pos_q    <= '0;
				first_q  <= 1'b0;
				status_q <= ibhq_pkg::ST_OK;
				case (ibhq_pkg::op_t'(opcode))
					ibhq_pkg::OP_INSERT: begin
						if (held_q[tag])
							status_q <= ibhq_pkg::ST_PRESENT;
						else if (cnt_q == CNT_W'(CAPACITY))
							status_q <= ibhq_pkg::ST_FULL;
					end
					ibhq_pkg::OP_REMOVE: begin
						if (!held_q[tag])
							status_q <= ibhq_pkg::ST_ABSENT;
					end
					default: begin
						if (cnt_q == '0)
							status_q <= ibhq_pkg::ST_EMPTY;
					end
				endcase
			end
			ibhq_pkg::S_POS: begin
				pos_q <= p_rdata;
				if (CNT_W'(p_rdata) >= cnt_q)
					status_q <= ibhq_pkg::ST_ABSENT;
			end
			ibhq_pkg::S_TGT: begin
				okey_q <= rd_key;
				otag_q <= rd_tag;
			end
			ibhq_pkg::S_LAST: begin
				m_key_q <= rd_key;
				m_tag_q <= rd_tag;
				idx_q   <= pos_q;
				first_q <= (pos_q != '0);
			end
			ibhq_pkg::S_UP_CMP: begin
				if (below) begin
					idx_q   <= parent;
					first_q <= 1'b0;
				end
			end
			ibhq_pkg::S_DN_L: begin
				if (below) begin
					best_key_q <= rd_key;
					best_tag_q <= rd_tag;
					best_idx_q <= lw[POS_W-1:0];
					best_mov_q <= 1'b0;
				end else begin
					best_key_q <= m_key_q;
					best_tag_q <= m_tag_q;
					best_idx_q <= idx_q;
					best_mov_q <= 1'b1;
				end
			end
			ibhq_pkg::S_DN_R: begin
				if (below) begin
					best_key_q <= rd_key;
					best_tag_q <= rd_tag;
					best_idx_q <= rw[POS_W-1:0];
					best_mov_q <= 1'b0;
				end
			end
			ibhq_pkg::S_DN_DEC: begin
				if (!best_mov_q)
					idx_q <= best_idx_q;
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != ibhq_pkg::S_IDLE);
	assign done      = (state_q == ibhq_pkg::S_DONE);
	assign status    = status_q;
	assign out_key   = okey_q;
	assign out_tag   = otag_q;
	assign occupancy = cnt_q;

endmodule

@@ rtl/indexed_binary_heap_queue.sv @@
// Flow from accept to result strobe: a rejected operation goes straight to the result; a peek
// reads the root; insert climbs level by level from the new last slot;
// pop moves the last entry to the root and sifts it down level by level;
// remove first looks up the tag's slot, refills it from the last entry and sifts it up or down.
// One item at a time: the next transfer is taken the cycle after the result strobe.
// Reset (arst_n low) empties the queue and selects min order; results cannot be stalled.
module indexed_binary_heap_queue #(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         opcode,
	input  logic [KEY_BITS-1:0]                key,
	input  logic [ibhq_pkg::TAG_W-1:0]         tag,
	output logic                               done,
	output logic [2:0]                         status,
	output logic [KEY_BITS-1:0]                out_key,
	output logic [ibhq_pkg::TAG_W-1:0]         out_tag,
	output logic [$clog2(CAPACITY+1)-1:0]      occupancy,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata
);

	localparam int POS_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY+1);
	localparam int ENT_W = KEY_BITS + ibhq_pkg::TAG_W;
	localparam int TW    = ibhq_pkg::TAG_W;

	logic order_max_q;

	logic             s_we;
	logic [POS_W-1:0] s_waddr, s_raddr;
	logic [ENT_W-1:0] s_wdata, s_rdata;
	logic             p_we;
	logic [TW-1:0]    p_waddr, p_raddr;
	logic [POS_W-1:0] p_wdata, p_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_max_q <= 1'b0;
		end else if (cfg_we) begin
			order_max_q <= cfg_wdata;
		end
	end

	ibhq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY), .AW(POS_W)) u_slots (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	ibhq_ram #(.WIDTH(POS_W), .DEPTH(ibhq_pkg::TAG_COUNT), .AW(TW)) u_pos (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	ibhq_ctrl #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .POS_W(POS_W), .CNT_W(CNT_W)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.opcode    (opcode),
		.key       (key),
		.tag       (tag),
		.order_max (order_max_q),
		.busy      (busy),
		.done      (done),
		.status    (status),
		.out_key   (out_key),
		.out_tag   (out_tag),
		.occupancy (occupancy),
		.s_we      (s_we),
		.s_waddr   (s_waddr),
		.s_wdata   (s_wdata),
		.s_raddr   (s_raddr),
		.s_rdata   (s_rdata),
		.p_we      (p_we),
		.p_waddr   (p_waddr),
		.p_wdata   (p_wdata),
		.p_raddr   (p_raddr),
		.p_rdata   (p_rdata)
	);

endmodule

@@ rtl/ibhq_check.sv @@
module ibhq_check #(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [2:0]                    status,
	input logic [KEY_BITS-1:0]           out_key,
	input logic [ibhq_pkg::TAG_W-1:0]    out_tag,
	input logic [$clog2(CAPACITY+1)-1:0] occupancy
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transfer did not raise busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("busy held after result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ibhq_pkg::ST_OK |-> out_key == '0 && out_tag == '0)
		else $error("rejected operation returned an entry");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ibhq_pkg::ST_EMPTY |-> occupancy == '0)
		else $error("empty status with entries held");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> occupancy <= ($clog2(CAPACITY+1))'(CAPACITY))
		else $error("occupancy above capacity");

endmodule

bind indexed_binary_heap_queue ibhq_check #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.out_key   (out_key),
	.out_tag   (out_tag),
	.occupancy (occupancy)
);

@@ dv/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 256;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		ibhq_pkg::op_t op;
		logic [15:0]   key;
		logic [7:0]    tag;
	} heap_cmd_t;

	typedef struct packed {
		ibhq_pkg::status_t st;
		logic [15:0]       key;
		logic [7:0]        tag;
		logic [8:0]        occ;
	} heap_resp_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [15:0] key;
	logic [7:0]  tag;
	logic        done;
	logic [2:0]  status;
	logic [15:0] out_key;
	logic [7:0]  out_tag;
	logic [8:0]  occupancy;
	logic        cfg_we;
	logic        cfg_wdata;

	indexed_binary_heap_queue #(.CAPACITY(CAP), .KEY_BITS(16)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .key(key), .tag(tag), .done(done), .status(status),
		.out_key(out_key), .out_tag(out_tag), .occupancy(occupancy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// shadow heap
	logic [15:0] hp_key [CAP];
	logic [7:0]  hp_tag [CAP];
	int          tag_slot [256];
	bit          tag_held [256];
	int          heap_count;
	bit          order_max;

	heap_cmd_t   cmd_q [$];
	heap_resp_t  resp_q [$];
	int          errors;
	int          idle_cycles;
	int          gap_left;
	int          burst_left;
	bit          drain_hold;

	function automatic bit sits_below(logic [15:0] a, logic [15:0] b);
		return order_max ? (a < b) : (a > b);
	endfunction

	function automatic void put_slot(int s, logic [15:0] k, logic [7:0] t);
		hp_key[s] = k;
		hp_tag[s] = t;
		tag_slot[t] = s;
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [15:0] k;
		logic [7:0]  t;
		k = hp_key[a];
		t = hp_tag[a];
		put_slot(a, hp_key[b], hp_tag[b]);
		put_slot(b, k, t);
	endfunction

	function automatic void bubble_up(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!sits_below(hp_key[p], hp_key[i])) break;
			swap_slots(p, i);
			i = p;
		end
	endfunction

	function automatic void bubble_down(int i);
		int t, l;
		forever begin
			t = i;
			l = 2 * i + 1;
			if (l < heap_count && sits_below(hp_key[t], hp_key[l])) t = l;
			if (l + 1 < heap_count && sits_below(hp_key[t], hp_key[l + 1])) t = l + 1;
			if (t == i) break;
			swap_slots(i, t);
			i = t;
		end
	endfunction

	function automatic void extract_slot(int pos);
		int last;
		last = heap_count - 1;
		tag_held[hp_tag[pos]] = 0;
		heap_count = last;
		if (pos != last) begin
			put_slot(pos, hp_key[last], hp_tag[last]);
			if (pos > 0 && sits_below(hp_key[(pos - 1) / 2], hp_key[pos]))
				bubble_up(pos);
			else
				bubble_down(pos);
		end
	endfunction

	function automatic heap_resp_t heap_apply(heap_cmd_t c);
		heap_resp_t r;
		r = '{st: ibhq_pkg::ST_OK, key: '0, tag: '0, occ: '0};
		case (c.op)
			ibhq_pkg::OP_INSERT: begin
				if (tag_held[c.tag]) r.st = ibhq_pkg::ST_PRESENT;
				else if (heap_count >= CAP) r.st = ibhq_pkg::ST_FULL;
				else begin
					put_slot(heap_count, c.key, c.tag);
					tag_held[c.tag] = 1;
					heap_count++;
					bubble_up(heap_count - 1);
				end
			end
			ibhq_pkg::OP_POP, ibhq_pkg::OP_FRONT: begin
				if (heap_count == 0) r.st = ibhq_pkg::ST_EMPTY;
				else begin
					r.key = hp_key[0];
					r.tag = hp_tag[0];
					if (c.op == ibhq_pkg::OP_POP) extract_slot(0);
				end
			end
			default: begin
				if (!tag_held[c.tag]) r.st = ibhq_pkg::ST_ABSENT;
				else begin
					r.key = hp_key[tag_slot[c.tag]];
					r.tag = c.tag;
					extract_slot(tag_slot[c.tag]);
				end
			end
		endcase
		r.occ = heap_count[8:0];
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			resp_q.push_back(heap_apply(cmd_q.pop_front()));
			idle_cycles <= 0;
		end else if (arst_n && done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// driver: one transfer at a time, bursts and gaps; raise start only while idle
	always @(negedge clk) begin
		if (!arst_n || drain_hold) begin
			start <= 0;
		end else if (start) begin
			// transfer taken at the last rising edge
			start <= 0;
		end else if (!busy) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (cmd_q.size() > 0) begin
				opcode <= cmd_q[0].op;
				key <= cmd_q[0].key;
				tag <= cmd_q[0].tag;
				start <= 1;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 15);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		heap_resp_t exp_r;
		if (arst_n && done) begin
			if (resp_q.size() == 0) begin
				$display("%0t: unexpected result status=%0d key=%0h tag=%0h occ=%0d",
					$time, status, out_key, out_tag, occupancy);
				errors++;
			end else begin
				exp_r = resp_q.pop_front();
				if (status !== exp_r.st || out_key !== exp_r.key ||
						out_tag !== exp_r.tag || occupancy !== exp_r.occ) begin
					$display("%0t: mismatch expected st=%0d key=%0h tag=%0h occ=%0d", $time,
						exp_r.st, exp_r.key, exp_r.tag, exp_r.occ);
					$display("%0t:          actual   st=%0d key=%0h tag=%0h occ=%0d", $time,
						status, out_key, out_tag, occupancy);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic void add_cmd(ibhq_pkg::op_t op, logic [15:0] k, logic [7:0] t);
		cmd_q.push_back('{op: op, key: k, tag: t});
	endfunction

	task automatic wait_drained();
		wait (cmd_q.size() == 0 && resp_q.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_order(bit m);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 0;
		order_max = m;
	endtask

	// random mix of inserts, pops, peeks and removes on random tags; fill_bias sets the insert share
	task automatic random_phase(int n, int fill_bias);
		int sel;
		logic [7:0] t;
		repeat (n) begin
			sel = $urandom_range(0, 99);
			t = 8'($urandom_range(0, 255));
			if (sel < fill_bias)
				add_cmd(ibhq_pkg::OP_INSERT, 16'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 7) : $urandom_range(0, 65535)), t);
			else if (sel < fill_bias + 15)
				add_cmd(ibhq_pkg::OP_POP, 16'($urandom_range(0, 65535)), t);
			else if (sel < fill_bias + 22)
				add_cmd(ibhq_pkg::OP_FRONT, 16'($urandom_range(0, 65535)), t);
			else
				add_cmd(ibhq_pkg::OP_REMOVE, 16'($urandom_range(0, 65535)), t);
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		opcode = '0;
		key = '0;
		tag = '0;
		cfg_we = 0;
		cfg_wdata = 0;
		errors = 0;
		idle_cycles = 0;
		gap_left = 0;
		burst_left = 0;
		drain_hold = 0;
		heap_count = 0;
		order_max = 0;
		for (int i = 0; i < 256; i++) begin
			tag_held[i] = 0;
			tag_slot[i] = 0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty cases, extremes, duplicates, equal keys
		add_cmd(ibhq_pkg::OP_POP, 16'hffff, 8'hff);
		add_cmd(ibhq_pkg::OP_FRONT, 16'h0, 8'h0);
		add_cmd(ibhq_pkg::OP_REMOVE, 16'h0, 8'h00);
		add_cmd(ibhq_pkg::OP_INSERT, 16'hffff, 8'hff);
		add_cmd(ibhq_pkg::OP_INSERT, 16'h0000, 8'h00);
		add_cmd(ibhq_pkg::OP_INSERT, 16'h8000, 8'h80);
		add_cmd(ibhq_pkg::OP_INSERT, 16'h8000, 8'h81);
		add_cmd(ibhq_pkg::OP_INSERT, 16'h1234, 8'h80);
		add_cmd(ibhq_pkg::OP_FRONT, 16'h0, 8'h0);
		add_cmd(ibhq_pkg::OP_REMOVE, 16'h0, 8'h81);
		add_cmd(ibhq_pkg::OP_REMOVE, 16'h0, 8'h81);
		add_cmd(ibhq_pkg::OP_POP, 16'h0, 8'h0);
		add_cmd(ibhq_pkg::OP_INSERT, 16'h5555, 8'h55);
		add_cmd(ibhq_pkg::OP_INSERT, 16'haaaa, 8'haa);
		wait_drained();
		// order flip with entries held
		set_order(1);
		add_cmd(ibhq_pkg::OP_INSERT, 16'h7fff, 8'h7f);
		add_cmd(ibhq_pkg::OP_POP, 16'h0, 8'h0);
		add_cmd(ibhq_pkg::OP_POP, 16'h0, 8'h0);
		random_phase(300, 60);
		wait_drained();

		// fill to capacity, then duplicates at capacity
		set_order(0);
		for (int i = 0; i < 256; i++)
			add_cmd(ibhq_pkg::OP_INSERT, 16'($urandom_range(0, 65535)), i[7:0]);
		add_cmd(ibhq_pkg::OP_INSERT, 16'h1, 8'h3);
		wait_drained();
		add_cmd(ibhq_pkg::OP_REMOVE, 16'h0, 8'h10);
		add_cmd(ibhq_pkg::OP_INSERT, 16'hffff, 8'h10);
		add_cmd(ibhq_pkg::OP_INSERT, 16'h0, 8'h10);
		random_phase(300, 35);
		wait_drained();

		set_order(1);
		random_phase(400, 55);
		wait_drained();
		set_order(0);
		random_phase(400, 45);
		wait_drained();

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ibhq_pkg.sv
rtl/ibhq_ram.sv
rtl/ibhq_ctrl.sv
rtl/indexed_binary_heap_queue.sv
rtl/ibhq_check.sv
dv/tb_top.sv
